@@ rtl/core/hli_pkg.sv @@
package hli_pkg;

	// Field widths of a transaction.
	localparam int FUNC_W = 2;
	localparam int HUB_W  = 32;
	localparam int DIST_W = 32;

	// Default number of entries per label list.
	localparam int LABEL_DEPTH_DEF = 256;

	// Distance that stands for an unreachable pair.
	localparam logic [DIST_W-1:0] UNREACH_DIST = {DIST_W{1'b1}};

	// Function codes of a request.
	localparam logic [FUNC_W-1:0] FUNC_LOAD_FWD = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_BWD = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 2'd2;

	// Request payload.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [HUB_W-1:0]  hub_id;
		logic [DIST_W-1:0] hub_dist;
	} req_t;

	// Response payload.
	typedef struct packed {
		logic [DIST_W-1:0] best_dist;
		logic              found;
		logic              overflowed;
	} rsp_t;

	// One stored label entry.
	typedef struct packed {
		logic [HUB_W-1:0]  hub;
		logic [DIST_W-1:0] cost;
	} entry_t;

	// Status from the list walker to the top level.
	typedef struct packed {
		logic busy;
		logic done;
	} walk_status_t;

endpackage

@@ rtl/core/hli_label_mem.sv @@
module hli_label_mem #(
	parameter int LABEL_DEPTH = hli_pkg::LABEL_DEPTH_DEF,
	localparam int IDX_W = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_addr,
	input  hli_pkg::entry_t        wr_data,
	input  logic [IDX_W-1:0]       rd_addr,
	output hli_pkg::entry_t        rd_data
);

	hli_pkg::entry_t mem_q [LABEL_DEPTH];
	hli_pkg::entry_t rd_data_q;

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/hli_walk.sv @@
module hli_walk #(
	parameter int LABEL_DEPTH = hli_pkg::LABEL_DEPTH_DEF,
	localparam int CNT_W = $clog2(LABEL_DEPTH + 1),
	localparam int IDX_W = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         rsp_full,
	input  logic [CNT_W-1:0]             fwd_count,
	input  logic [CNT_W-1:0]             bwd_count,
	output logic [IDX_W-1:0]             fwd_addr,
	output logic [IDX_W-1:0]             bwd_addr,
	input  hli_pkg::entry_t              fwd_entry,
	input  hli_pkg::entry_t              bwd_entry,
	output hli_pkg::walk_status_t        status,
	output logic [hli_pkg::DIST_W-1:0]   best_dist
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            i_q;
	logic [CNT_W-1:0]            j_q;
	logic [hli_pkg::DIST_W-1:0]  best_q;

	// Shared compare and add unit, used once per step of the walk.
	logic [hli_pkg::DIST_W:0] sum;
	logic                     hub_eq;
	logic                     hub_lt;
	logic                     sum_lt;

	assign sum    = {1'b0, fwd_entry.cost} + {1'b0, bwd_entry.cost};
	assign hub_eq = (fwd_entry.hub == bwd_entry.hub);
	assign hub_lt = (fwd_entry.hub < bwd_entry.hub);
	assign sum_lt = (sum < {1'b0, best_q});

	// The memories read at the current pointers.
	assign fwd_addr = i_q[IDX_W-1:0];
	assign bwd_addr = j_q[IDX_W-1:0];

	// Sequencer: check pointers, read both lists, compare, repeat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			best_q  <= hli_pkg::UNREACH_DIST;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						i_q     <= '0;
						j_q     <= '0;
						best_q  <= hli_pkg::UNREACH_DIST;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if ((i_q < fwd_count) && (j_q < bwd_count)) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_CMP: begin
					if (hub_eq) begin
						if (sum_lt) begin
							best_q <= sum[hli_pkg::DIST_W-1:0];
						end
						i_q <= i_q + CNT_W'(1);
						j_q <= j_q + CNT_W'(1);
					end else if (hub_lt) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
					state_q <= ST_CHECK;
				end
				ST_FINISH: begin
					if (!rsp_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.done = (state_q == ST_FINISH) && !rsp_full;
	assign best_dist   = best_q;

endmodule

@@ rtl/core/hub_label_intersect_min.sv @@
// Hub-label distance query.
// Request channel (req, req_valid, req_stall): func 0 appends an entry to the
// forward list, func 1 to the backward list, func 2 runs a query, and func 3
// is ignored. Lists are expected in ascending hub order.
// Load transactions are taken one per cycle while no query is running and give no response.
// A query walks both lists with two pointers through the shared compare and
// add unit; each step has a check state and then a compare state, as the
// memory read is registered. A query holds req_stall until its result is
// stored, taking at most the forward plus backward count minus one steps.
// The response (rsp, rsp_valid, rsp_stall) carries the minimum summed
// distance, a found flag and the overflow flag. It sits in an output
// register, so loads are taken while it waits; a further query finishes its
// walk and then waits until that register is free.
// Loads beyond LABEL_DEPTH entries are dropped and reported. A query
// empties both lists and clears the overflow flag.
// Reset empties both lists and clears the drop and response valid flags; list contents are not
// cleared, since only entries below the counts are ever read.
module hub_label_intersect_min #(
	parameter int LABEL_DEPTH = hli_pkg::LABEL_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hli_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hli_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(LABEL_DEPTH + 1);
	localparam int IDX_W = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LABEL_DEPTH);

	logic [CNT_W-1:0]           fwd_count_q;
	logic [CNT_W-1:0]           bwd_count_q;
	logic                       drop_q;
	logic                       rsp_valid_q;
	hli_pkg::rsp_t              rsp_q;

	logic                       accept;
	logic                       fwd_wr;
	logic                       bwd_wr;
	logic                       start;
	logic                       rsp_full;
	logic [IDX_W-1:0]           fwd_addr;
	logic [IDX_W-1:0]           bwd_addr;
	hli_pkg::entry_t            wr_entry;
	hli_pkg::entry_t            fwd_entry;
	hli_pkg::entry_t            bwd_entry;
	hli_pkg::walk_status_t      status;
	logic [hli_pkg::DIST_W-1:0] best_dist;

	// Request decode.
	assign accept   = req_valid && !req_stall;
	assign fwd_wr   = accept && (req.func == hli_pkg::FUNC_LOAD_FWD) &&
	                  (fwd_count_q < DEPTH_CNT);
	assign bwd_wr   = accept && (req.func == hli_pkg::FUNC_LOAD_BWD) &&
	                  (bwd_count_q < DEPTH_CNT);
	assign start    = accept && (req.func == hli_pkg::FUNC_COMPUTE);
	assign req_stall = status.busy;
	assign rsp_full = rsp_valid_q && rsp_stall;

	assign wr_entry.hub  = req.hub_id;
	assign wr_entry.cost = req.hub_dist;

	hli_label_mem #(
		.LABEL_DEPTH(LABEL_DEPTH)
	) u_fwd_mem (
		.clk    (clk),
		.wr_en  (fwd_wr),
		.wr_addr(fwd_count_q[IDX_W-1:0]),
		.wr_data(wr_entry),
		.rd_addr(fwd_addr),
		.rd_data(fwd_entry)
	);

	hli_label_mem #(
		.LABEL_DEPTH(LABEL_DEPTH)
	) u_bwd_mem (
		.clk    (clk),
		.wr_en  (bwd_wr),
		.wr_addr(bwd_count_q[IDX_W-1:0]),
		.wr_data(wr_entry),
		.rd_addr(bwd_addr),
		.rd_data(bwd_entry)
	);

	hli_walk #(
		.LABEL_DEPTH(LABEL_DEPTH)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.rsp_full (rsp_full),
		.fwd_count(fwd_count_q),
		.bwd_count(bwd_count_q),
		.fwd_addr (fwd_addr),
		.bwd_addr (bwd_addr),
		.fwd_entry(fwd_entry),
		.bwd_entry(bwd_entry),
		.status   (status),
		.best_dist(best_dist)
	);

	// List counts and the drop flag; a finished query clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_count_q <= '0;
			bwd_count_q <= '0;
			drop_q      <= 1'b0;
		end else if (status.done) begin
			fwd_count_q <= '0;
			bwd_count_q <= '0;
			drop_q      <= 1'b0;
		end else if (accept) begin
			if (fwd_wr) begin
				fwd_count_q <= fwd_count_q + CNT_W'(1);
			end
			if (bwd_wr) begin
				bwd_count_q <= bwd_count_q + CNT_W'(1);
			end
			if (((req.func == hli_pkg::FUNC_LOAD_FWD) && !fwd_wr) ||
			    ((req.func == hli_pkg::FUNC_LOAD_BWD) && !bwd_wr)) begin
				drop_q <= 1'b1;
			end
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (status.done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (status.done) begin
			rsp_q.best_dist  <= best_dist;
			rsp_q.found      <= (best_dist != hli_pkg::UNREACH_DIST);
			rsp_q.overflowed <= drop_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
